### src/sqv_pkg.sv
// ----------------------------------------------------------------------------
// sqv_pkg
// Shared constants, types and the quarter-wave sine table for the sprite
// quad vertex generator.
// ----------------------------------------------------------------------------
package sqv_pkg;

  // Format of angles and coordinates
  localparam int ANGLE_BITS = 12;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int QTR_W      = ANGLE_BITS - 2;
  localparam int QTR        = 1 << QTR_W;
  localparam int ONE        = 1 << FRAC_BITS;

  // Field widths
  localparam int DIM_W   = 15;
  localparam int SRC_W   = 14;
  localparam int SCR_W   = 14;
  localparam int TEX_W   = 15;
  localparam int COLOR_W = 32;
  localparam int TEXO_W  = FRAC_BITS + 2;

  // Datapath widths
  localparam int TRIG_W = FRAC_BITS + 2;               // signed sine / cosine
  localparam int HALF_W = DIM_W + 1;                   // signed half extent
  localparam int CW     = COORD_BITS + 2;              // doubled centre
  localparam int PW     = TRIG_W + HALF_W;             // rotation product
  localparam int XW     = CW + FRAC_BITS + 1;          // doubled corner, Q.F
  localparam int MW     = XW + 2;                      // signed dividend
  localparam int DW     = MW - 1;                      // divider remainder
  localparam int KXW    = SCR_W + FRAC_BITS + 2;       // dividend offset
  localparam int DEN_W  = TEX_W + 1;                   // doubled divisor
  localparam int QB     = ((TEXO_W > COORD_BITS - 1) ? TEXO_W : COORD_BITS - 1) + 1;

  // Divider lanes
  localparam int NLANE  = 4;
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_U = 2;
  localparam int LANE_V = 3;

  // Vertex sequence
  localparam int NVERT = 6;
  localparam int KW    = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TEX_W    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TEX_H    = CFG_IDX_W'(3);
  localparam logic [SCR_W-1:0] RST_SCREEN_W = SCR_W'(1280);
  localparam logic [SCR_W-1:0] RST_SCREEN_H = SCR_W'(720);
  localparam logic [TEX_W-1:0] RST_TEX_W    = TEX_W'(1);
  localparam logic [TEX_W-1:0] RST_TEX_H    = TEX_W'(1);

  // Sine table, Q1.FRAC_BITS, entries 0..QTR
  typedef logic [FRAC_BITS:0] rom_t [QTR+1];

  function automatic rom_t build_rom();
    rom_t rom;
    logic [63:0] z, z2, t, t2, t3, t4, s;
    int p;
    for (p = 0; p <= QTR; p++) begin
      z  = 64'(p) << (32 - ANGLE_BITS);
      z2 = (z * z) >> 30;
      t  = (64'd152033954 * z2) >> 30;
      t2 = 64'd1377809732 - t;
      t3 = (t2 * z2) >> 30;
      t4 = 64'd3373259426 - t3;
      s  = (z * t4) >> 31;
      rom[p] = (FRAC_BITS+1)'((s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Corner of each vertex in the two-triangle order
  function automatic logic [1:0] corner_of(logic [KW-1:0] k);
    logic [1:0] c;
    unique case (k)
      KW'(0):  c = 2'd0;
      KW'(1):  c = 2'd1;
      KW'(2):  c = 2'd2;
      KW'(3):  c = 2'd2;
      KW'(4):  c = 2'd1;
      default: c = 2'd3;
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic signed [COORD_BITS-1:0] dest_x;
    logic signed [COORD_BITS-1:0] dest_y;
    logic [DIM_W-1:0]             dest_w;
    logic [DIM_W-1:0]             dest_h;
    logic [COLOR_W-1:0]           color_rgba;
    logic [ANGLE_BITS-1:0]        turn_angle;
    logic [SRC_W-1:0]             src_x;
    logic [SRC_W-1:0]             src_y;
    logic [SRC_W-1:0]             src_w;
    logic [SRC_W-1:0]             src_h;
  } sprite_t;

  typedef struct packed {
    sprite_t    spr;
    logic [1:0] corner;
    logic       last;
  } vert_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [1:0]         corner;
    logic               last;
  } side_t;

  typedef struct packed {
    logic [NLANE-1:0][DW-1:0] rem;
    logic [NLANE-1:0]         lo;
    side_t                    side;
  } div_in_t;

  typedef struct packed {
    logic [NLANE-1:0][DW-1:0] rem;
    logic [NLANE-1:0][QB-1:0] quo;
    logic [NLANE-1:0]         lo;
    logic [NLANE-1:0]         hi;
    side_t                    side;
  } div_st_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ndc_x;
    logic signed [COORD_BITS-1:0] ndc_y;
    logic [TEXO_W-1:0]            tex_u;
    logic [TEXO_W-1:0]            tex_v;
    logic [COLOR_W-1:0]           color;
    logic [1:0]                   corner;
    logic                         last;
  } vtx_t;

endpackage

### src/sqv_if.sv
// ----------------------------------------------------------------------------
// sqv_if
// Channel interfaces: sprite input, vertex output and register writes.
// ----------------------------------------------------------------------------
interface sqv_in_if;
  import sqv_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] dest_x;
  logic signed [COORD_BITS-1:0] dest_y;
  logic [DIM_W-1:0]             dest_w;
  logic [DIM_W-1:0]             dest_h;
  logic [COLOR_W-1:0]           color_rgba;
  logic [ANGLE_BITS-1:0]        turn_angle;
  logic [SRC_W-1:0]             src_x;
  logic [SRC_W-1:0]             src_y;
  logic [SRC_W-1:0]             src_w;
  logic [SRC_W-1:0]             src_h;

  modport source(output valid, dest_x, dest_y, dest_w, dest_h, color_rgba, turn_angle,
                 src_x, src_y, src_w, src_h, input ready);
  modport sink(input valid, dest_x, dest_y, dest_w, dest_h, color_rgba, turn_angle,
               src_x, src_y, src_w, src_h, output ready);
endinterface

interface sqv_out_if;
  import sqv_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ndc_x;
  logic signed [COORD_BITS-1:0] ndc_y;
  logic [TEXO_W-1:0]            tex_u;
  logic [TEXO_W-1:0]            tex_v;
  logic [COLOR_W-1:0]           vertex_color;
  logic [1:0]                   corner;
  logic                         last;

  modport source(output valid, ndc_x, ndc_y, tex_u, tex_v, vertex_color, corner, last,
                 input ready);
  modport sink(input valid, ndc_x, ndc_y, tex_u, tex_v, vertex_color, corner, last,
               output ready);
endinterface

interface sqv_cfg_if;
  import sqv_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### src/sqv_seq.sv
// ----------------------------------------------------------------------------
// sqv_seq
// Holds one sprite and issues its six vertices, one per cycle while vert_ready is high.
// ----------------------------------------------------------------------------
module sqv_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  sqv_pkg::sprite_t in_spr,
  output logic            in_ready,
  output logic            vert_valid,
  output sqv_pkg::vert_t  vert,
  input  logic            vert_ready
);
  import sqv_pkg::*;

  logic            hold_r;
  logic [KW-1:0]   k_r;
  sprite_t         spr_r;
  logic            at_last;

  // Issue the current vertex of the held sprite
  always_comb begin
    at_last     = (k_r == KW'(NVERT - 1));
    vert_valid  = hold_r;
    vert.spr    = spr_r;
    vert.corner = corner_of(k_r);
    vert.last   = at_last;
    in_ready    = !hold_r || (at_last && vert_ready);
  end

  // Advance the vertex count, take the next sprite on the final transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      k_r    <= '0;
    end else if (in_valid && in_ready) begin
      hold_r <= 1'b1;
      k_r    <= '0;
    end else if (hold_r && vert_ready) begin
      if (at_last) begin
        hold_r <= 1'b0;
      end
      k_r <= k_r + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      spr_r <= in_spr;
    end
  end

endmodule

### src/sqv_geom.sv
// ----------------------------------------------------------------------------
// sqv_geom
// Four-stage geometry front end: trig lookup, rotation products, corner sum
// and dividend forming for the four divider lanes.
// ----------------------------------------------------------------------------
module sqv_geom (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [sqv_pkg::SCR_W-1:0]             screen_w,
  input  logic [sqv_pkg::SCR_W-1:0]             screen_h,
  input  logic [sqv_pkg::TEX_W-1:0]             tex_w,
  input  logic [sqv_pkg::TEX_W-1:0]             tex_h,
  input  logic                                  vert_valid,
  input  sqv_pkg::vert_t                        vert,
  output logic                                  vert_ready,
  output logic                                  div_valid,
  output sqv_pkg::div_in_t                      div_data,
  input  logic                                  div_ready
);
  import sqv_pkg::*;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sn;
    logic signed [TRIG_W-1:0] cs;
    logic signed [HALF_W-1:0] hx;
    logic signed [HALF_W-1:0] hy;
    logic signed [CW-1:0]     cx2;
    logic signed [CW-1:0]     cy2;
    logic [SRC_W:0]           eu;
    logic [SRC_W:0]           ev;
    side_t                    side;
  } geo_a_t;

  typedef struct packed {
    logic signed [PW-1:0] pxc;
    logic signed [PW-1:0] pys;
    logic signed [PW-1:0] pxs;
    logic signed [PW-1:0] pyc;
    logic signed [CW-1:0] cx2;
    logic signed [CW-1:0] cy2;
    logic [SRC_W:0]       eu;
    logic [SRC_W:0]       ev;
    side_t                side;
  } geo_b_t;

  typedef struct packed {
    logic signed [XW-1:0] x2;
    logic signed [XW-1:0] y2;
    logic [SRC_W:0]       eu;
    logic [SRC_W:0]       ev;
    side_t                side;
  } geo_c_t;

  logic    va_r, vb_r, vc_r, vd_r;
  logic    rdy_a, rdy_b, rdy_c, rdy_d;
  geo_a_t  a_r, a_nxt;
  geo_b_t  b_r, b_nxt;
  geo_c_t  c_r, c_nxt;
  div_in_t d_r, d_nxt;

  // Stall chain: a stage moves when it is empty or its successor moves
  always_comb begin
    rdy_d      = !vd_r || div_ready;
    rdy_c      = !vc_r || rdy_d;
    rdy_b      = !vb_r || rdy_c;
    rdy_a      = !va_r || rdy_b;
    vert_ready = rdy_a;
    div_valid  = vd_r;
    div_data   = d_r;
  end

  // Stage A: sine and cosine by quadrant, half extents, doubled centre
  logic [1:0]             quad;
  logic [QTR_W-1:0]       pa;
  logic [QTR_W:0]         pb;
  logic signed [TRIG_W-1:0] sa, sb;
  logic signed [HALF_W-1:0] wh, hh;

  always_comb begin
    quad = vert.spr.turn_angle[ANGLE_BITS-1 -: 2];
    pa   = vert.spr.turn_angle[QTR_W-1:0];
    pb   = (QTR_W+1)'(QTR) - {1'b0, pa};
    sa   = signed'(TRIG_W'(SINE_ROM[{1'b0, pa}]));
    sb   = signed'(TRIG_W'(SINE_ROM[pb]));
    wh   = signed'({1'b0, vert.spr.dest_w});
    hh   = signed'({1'b0, vert.spr.dest_h});
    unique case (quad)
      2'd0: begin a_nxt.sn = sa;  a_nxt.cs = sb;  end
      2'd1: begin a_nxt.sn = sb;  a_nxt.cs = -sa; end
      2'd2: begin a_nxt.sn = -sa; a_nxt.cs = -sb; end
      default: begin a_nxt.sn = -sb; a_nxt.cs = sa; end
    endcase
    a_nxt.hx  = vert.corner[0] ? wh : -wh;
    a_nxt.hy  = vert.corner[1] ? hh : -hh;
    a_nxt.cx2 = (CW'(vert.spr.dest_x) <<< 1) + CW'(wh);
    a_nxt.cy2 = (CW'(vert.spr.dest_y) <<< 1) + CW'(hh);
    a_nxt.eu  = vert.corner[0] ? ((SRC_W+1)'(vert.spr.src_x) + (SRC_W+1)'(vert.spr.src_w))
                               : (SRC_W+1)'(vert.spr.src_x);
    a_nxt.ev  = vert.corner[1] ? ((SRC_W+1)'(vert.spr.src_y) + (SRC_W+1)'(vert.spr.src_h))
                               : (SRC_W+1)'(vert.spr.src_y);
    a_nxt.side.color  = vert.spr.color_rgba;
    a_nxt.side.corner = vert.corner;
    a_nxt.side.last   = vert.last;
  end

  // Stage B: rotation products
  always_comb begin
    b_nxt.pxc  = a_r.cs * a_r.hx;
    b_nxt.pys  = a_r.sn * a_r.hy;
    b_nxt.pxs  = a_r.sn * a_r.hx;
    b_nxt.pyc  = a_r.cs * a_r.hy;
    b_nxt.cx2  = a_r.cx2;
    b_nxt.cy2  = a_r.cy2;
    b_nxt.eu   = a_r.eu;
    b_nxt.ev   = a_r.ev;
    b_nxt.side = a_r.side;
  end

  // Stage C: doubled corner position in Q.FRAC_BITS
  always_comb begin
    c_nxt.x2   = (XW'(b_r.cx2) <<< FRAC_BITS) + XW'(b_r.pxc) - XW'(b_r.pys);
    c_nxt.y2   = (XW'(b_r.cy2) <<< FRAC_BITS) + XW'(b_r.pxs) + XW'(b_r.pyc);
    c_nxt.eu   = b_r.eu;
    c_nxt.ev   = b_r.ev;
    c_nxt.side = b_r.side;
  end

  // Stage D: dividends with the rounding half and the low clamp offset
  logic [KXW-1:0]       kx, ky;
  logic signed [MW-1:0] mx, my;

  always_comb begin
    kx = (KXW'(screen_w) << (FRAC_BITS + 1)) + KXW'(screen_w);
    ky = (KXW'(screen_h) << (FRAC_BITS + 1)) + KXW'(screen_h);
    mx = (MW'(c_r.x2) <<< 1) + MW'(signed'({1'b0, kx}));
    my = (MW'(c_r.y2) <<< 1) + MW'(signed'({1'b0, ky}));
    d_nxt.rem[LANE_X] = mx[DW-1:0];
    d_nxt.lo[LANE_X]  = mx[MW-1];
    d_nxt.rem[LANE_Y] = my[DW-1:0];
    d_nxt.lo[LANE_Y]  = my[MW-1];
    d_nxt.rem[LANE_U] = (DW'(c_r.eu) << (FRAC_BITS + 1)) + DW'(tex_w);
    d_nxt.lo[LANE_U]  = 1'b0;
    d_nxt.rem[LANE_V] = (DW'(c_r.ev) << (FRAC_BITS + 1)) + DW'(tex_h);
    d_nxt.lo[LANE_V]  = 1'b0;
    d_nxt.side        = c_r.side;
  end

  // Hold or advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= vert_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) a_r <= a_nxt;
    if (rdy_b) b_r <= b_nxt;
    if (rdy_c) c_r <= c_nxt;
    if (rdy_d) d_r <= d_nxt;
  end

endmodule

### src/sqv_div.sv
// ----------------------------------------------------------------------------
// sqv_div
// Four-lane restoring divider, one quotient bit per stage, with an overflow
// check stage at the top. Valid bits travel with each stage.
// ----------------------------------------------------------------------------
module sqv_div (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic [sqv_pkg::NLANE-1:0][sqv_pkg::DEN_W-1:0] den,
  input  logic                                         in_valid,
  input  sqv_pkg::div_in_t                             in_data,
  output logic                                         in_ready,
  output logic                                         out_valid,
  output sqv_pkg::div_st_t                             out_data,
  input  logic                                         out_ready
);
  import sqv_pkg::*;

  localparam int NST = QB + 1;

  logic [NST-1:0] v_r;
  logic [NST:0]   rdy;
  div_st_t        st_r [NST];

  assign rdy[NST]  = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = v_r[NST-1];
  assign out_data  = st_r[NST-1];

  for (genvar j = 0; j < NST; j++) begin : g_st
    div_st_t nxt;
    logic    vin;

    assign rdy[j] = !v_r[j] || rdy[j+1];

    if (j == 0) begin : g_top
      // Flag quotients that exceed the quotient width
      always_comb begin
        nxt.rem  = in_data.rem;
        nxt.quo  = '0;
        nxt.lo   = in_data.lo;
        nxt.side = in_data.side;
        for (int l = 0; l < NLANE; l++) begin
          nxt.hi[l] = (in_data.rem[l] >= (DW'(den[l]) << QB));
        end
        vin = in_valid;
      end
    end else begin : g_bit
      // Trial subtract for quotient bit QB-j
      always_comb begin
        nxt = st_r[j-1];
        for (int l = 0; l < NLANE; l++) begin
          if (st_r[j-1].rem[l] >= (DW'(den[l]) << (QB - j))) begin
            nxt.rem[l]         = st_r[j-1].rem[l] - (DW'(den[l]) << (QB - j));
            nxt.quo[l][QB - j] = 1'b1;
          end
        end
        vin = v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_r[j] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        st_r[j] <= nxt;
      end
    end
  end

endmodule

### src/sqv_out.sv
// ----------------------------------------------------------------------------
// sqv_out
// Turns quotients into clamped NDC and texture coordinates and holds the
// vertex in the output register.
// ----------------------------------------------------------------------------
module sqv_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  sqv_pkg::div_st_t in_data,
  output logic             in_ready,
  output logic             out_valid,
  output sqv_pkg::vtx_t    out_vtx,
  input  logic             out_ready
);
  import sqv_pkg::*;

  localparam int S = QB + 2;
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [TEXO_W-1:0]            T_MAX = {TEXO_W{1'b1}};

  logic                valid_r;
  vtx_t                vtx_r, vtx_nxt;
  logic signed [S-1:0] nx, ny;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_vtx   = vtx_r;

  // Remove the two offsets of one and clamp
  always_comb begin
    nx = signed'(S'(in_data.quo[LANE_X])) - signed'(S'(2 * ONE));
    ny = signed'(S'(2 * ONE)) - signed'(S'(in_data.quo[LANE_Y]));

    priority if (in_data.lo[LANE_X])   vtx_nxt.ndc_x = C_MIN;
    else if (in_data.hi[LANE_X])       vtx_nxt.ndc_x = C_MAX;
    else if (nx > S'(C_MAX))           vtx_nxt.ndc_x = C_MAX;
    else if (nx < S'(C_MIN))           vtx_nxt.ndc_x = C_MIN;
    else                               vtx_nxt.ndc_x = nx[COORD_BITS-1:0];

    priority if (in_data.lo[LANE_Y])   vtx_nxt.ndc_y = C_MAX;
    else if (in_data.hi[LANE_Y])       vtx_nxt.ndc_y = C_MIN;
    else if (ny > S'(C_MAX))           vtx_nxt.ndc_y = C_MAX;
    else if (ny < S'(C_MIN))           vtx_nxt.ndc_y = C_MIN;
    else                               vtx_nxt.ndc_y = ny[COORD_BITS-1:0];

    if (in_data.hi[LANE_U] || (in_data.quo[LANE_U] > QB'(T_MAX))) begin
      vtx_nxt.tex_u = T_MAX;
    end else begin
      vtx_nxt.tex_u = in_data.quo[LANE_U][TEXO_W-1:0];
    end
    if (in_data.hi[LANE_V] || (in_data.quo[LANE_V] > QB'(T_MAX))) begin
      vtx_nxt.tex_v = T_MAX;
    end else begin
      vtx_nxt.tex_v = in_data.quo[LANE_V][TEXO_W-1:0];
    end

    vtx_nxt.color  = in_data.side.color;
    vtx_nxt.corner = in_data.side.corner;
    vtx_nxt.last   = in_data.side.last;
  end

  // Output register: load when empty or when the vertex is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      vtx_r <= vtx_nxt;
    end
  end

endmodule

### src/sprite_quad_vertex_gen.sv
// ----------------------------------------------------------------------------
// sprite_quad_vertex_gen
// Rotated sprite quad to NDC vertex generator, top level.
// ----------------------------------------------------------------------------
// Each accepted sprite yields six vertices (corners 0,1,2 then 2,1,3), one
// per cycle on the output channel while it is ready; the vertex sequencer
// takes a new sprite only when idle or as the last vertex is handed on.
// Each vertex passes the sequencer, four geometry stages, an 18-stage
// divider (one quotient bit per stage after an overflow check) and the
// output register. The user must write screen and texture sizes through
// the configuration port only while the block is idle; the block does not
// enforce this. A size of zero acts as one. No clearing pass follows reset.
module sprite_quad_vertex_gen (
  input  logic      clk,
  input  logic      rst_n,
  sqv_in_if.sink    in_ch,
  sqv_out_if.source out_ch,
  sqv_cfg_if.sink   cfg_ch
);
  import sqv_pkg::*;

  logic [SCR_W-1:0] screen_w_r, screen_h_r;
  logic [TEX_W-1:0] tex_w_r, tex_h_r;
  logic [SCR_W-1:0] scr_val;
  logic [TEX_W-1:0] tex_val;

  // Register writes, zero sizes stored as one
  assign cfg_ch.ready = 1'b1;
  assign scr_val = (cfg_ch.data[SCR_W-1:0] == '0) ? SCR_W'(1) : cfg_ch.data[SCR_W-1:0];
  assign tex_val = (cfg_ch.data[TEX_W-1:0] == '0) ? TEX_W'(1) : cfg_ch.data[TEX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= RST_SCREEN_W;
      screen_h_r <= RST_SCREEN_H;
      tex_w_r    <= RST_TEX_W;
      tex_h_r    <= RST_TEX_H;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SCREEN_W: screen_w_r <= scr_val;
        REG_SCREEN_H: screen_h_r <= scr_val;
        REG_TEX_W:    tex_w_r    <= tex_val;
        REG_TEX_H:    tex_h_r    <= tex_val;
        default: ;
      endcase
    end
  end

  // Gather the sprite fields
  sprite_t in_spr;
  always_comb begin
    in_spr.dest_x     = in_ch.dest_x;
    in_spr.dest_y     = in_ch.dest_y;
    in_spr.dest_w     = in_ch.dest_w;
    in_spr.dest_h     = in_ch.dest_h;
    in_spr.color_rgba = in_ch.color_rgba;
    in_spr.turn_angle = in_ch.turn_angle;
    in_spr.src_x      = in_ch.src_x;
    in_spr.src_y      = in_ch.src_y;
    in_spr.src_w      = in_ch.src_w;
    in_spr.src_h      = in_ch.src_h;
  end

  logic    vert_valid, vert_ready;
  vert_t   vert;
  logic    dv_valid, dv_ready;
  div_in_t dv_data;
  logic    dq_valid, dq_ready;
  div_st_t dq_data;
  logic    in_ready;
  vtx_t    vtx;
  logic    vtx_valid;
  logic [NLANE-1:0][DEN_W-1:0] den;

  always_comb begin
    den[LANE_X] = DEN_W'({screen_w_r, 1'b0});
    den[LANE_Y] = DEN_W'({screen_h_r, 1'b0});
    den[LANE_U] = DEN_W'({tex_w_r, 1'b0});
    den[LANE_V] = DEN_W'({tex_h_r, 1'b0});
  end

  assign in_ch.ready = in_ready;

  sqv_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_spr     (in_spr),
    .in_ready   (in_ready),
    .vert_valid (vert_valid),
    .vert       (vert),
    .vert_ready (vert_ready)
  );

  sqv_geom u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .screen_w   (screen_w_r),
    .screen_h   (screen_h_r),
    .tex_w      (tex_w_r),
    .tex_h      (tex_h_r),
    .vert_valid (vert_valid),
    .vert       (vert),
    .vert_ready (vert_ready),
    .div_valid  (dv_valid),
    .div_data   (dv_data),
    .div_ready  (dv_ready)
  );

  sqv_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .den       (den),
    .in_valid  (dv_valid),
    .in_data   (dv_data),
    .in_ready  (dv_ready),
    .out_valid (dq_valid),
    .out_data  (dq_data),
    .out_ready (dq_ready)
  );

  sqv_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dq_valid),
    .in_data   (dq_data),
    .in_ready  (dq_ready),
    .out_valid (vtx_valid),
    .out_vtx   (vtx),
    .out_ready (out_ch.ready)
  );

  // Drive the result channel
  assign out_ch.valid        = vtx_valid;
  assign out_ch.ndc_x        = vtx.ndc_x;
  assign out_ch.ndc_y        = vtx.ndc_y;
  assign out_ch.tex_u        = vtx.tex_u;
  assign out_ch.tex_v        = vtx.tex_v;
  assign out_ch.vertex_color = vtx.color;
  assign out_ch.corner       = vtx.corner;
  assign out_ch.last         = vtx.last;

endmodule
